// ----- design/euq_pkg.sv -----
// Shared constants, types and the arctangent table for the Euler-to-quaternion pipeline.
package euq_pkg;

    localparam int CORDIC_STEPS_DEF  = 16;
    localparam int OUT_FRAC_BITS_DEF = 14;
    localparam int TABLE_LEN         = 24;

    localparam int NUM_ANG = 3;
    localparam int ANG_W   = 16;
    localparam int OUT_W   = 16;
    localparam int Q_FRAC  = 30;
    localparam int H_W     = 34;
    localparam int XY_W    = 34;
    localparam int TRIG_W  = 32;

    // lane order inside the pipeline
    localparam int LANE_YAW   = 0;
    localparam int LANE_PITCH = 1;
    localparam int LANE_ROLL  = 2;

    localparam logic signed [ANG_W-1:0] ANG_LIMIT   = 16'sd25736;
    localparam logic signed [H_W-1:0]   PI_Q30      = 34'sd3373259426;
    localparam logic signed [H_W-1:0]   HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [XY_W-1:0]  GAIN_Q30    = 34'sd652032874;

    typedef struct packed {
        logic signed [TRIG_W-1:0] sin_v;
        logic signed [TRIG_W-1:0] cos_v;
    } trig_t;

    // atan(2^-i) in Q30, truncated
    function automatic logic signed [H_W-1:0] atan_q30(input int unsigned idx);
        logic signed [H_W-1:0] val;
        case (idx)
            0:       val = 34'sh03243F6A8;
            1:       val = 34'sh01DAC6705;
            2:       val = 34'sh00FADBAFC;
            3:       val = 34'sh007F56EA6;
            4:       val = 34'sh003FEAB76;
            5:       val = 34'sh001FFD55B;
            6:       val = 34'sh000FFFAAA;
            7:       val = 34'sh0007FFF55;
            8:       val = 34'sh0003FFFEA;
            9:       val = 34'sh0001FFFFD;
            10:      val = 34'sh0000FFFFF;
            11:      val = 34'sh00007FFFF;
            12:      val = 34'sh00003FFFF;
            13:      val = 34'sh00001FFFF;
            14:      val = 34'sh00000FFFF;
            15:      val = 34'sh000007FFF;
            16:      val = 34'sh000003FFF;
            17:      val = 34'sh000001FFF;
            18:      val = 34'sh000000FFF;
            19:      val = 34'sh0000007FF;
            20:      val = 34'sh0000003FF;
            21:      val = 34'sh0000001FF;
            22:      val = 34'sh0000000FF;
            23:      val = 34'sh00000007F;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// ----- design/euq_cordic.sv -----
// Three-lane pipelined CORDIC: clamp, halve, fold; one iteration per stage; then undo the fold.
module euq_cordic #(
    parameter int CORDIC_STEPS = euq_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                                 aclk,
    input  logic                                                 aresetn,
    input  logic                                                 in_valid,
    output logic                                                 in_ready,
    input  logic [euq_pkg::NUM_ANG-1:0][euq_pkg::ANG_W-1:0]      angle,
    output logic                                                 out_valid,
    input  logic                                                 out_ready,
    output euq_pkg::trig_t [euq_pkg::NUM_ANG-1:0]                trig
);

    localparam int STEPS = (CORDIC_STEPS > euq_pkg::TABLE_LEN) ? euq_pkg::TABLE_LEN
                                                                : CORDIC_STEPS;
    localparam int LAST  = STEPS + 1;
    localparam int NA    = euq_pkg::NUM_ANG;
    localparam int H_W   = euq_pkg::H_W;
    localparam int XY_W  = euq_pkg::XY_W;
    localparam int HSH   = euq_pkg::Q_FRAC - 12 - 1;   // Q12 to Q30, halved

    logic [LAST:0] v_reg;
    logic [LAST:0] en;

    logic signed [H_W-1:0]  h_reg   [0:STEPS][0:NA-1];
    logic                   neg_reg [0:STEPS][0:NA-1];
    logic signed [XY_W-1:0] x_reg   [1:STEPS][0:NA-1];
    logic signed [XY_W-1:0] y_reg   [1:STEPS][0:NA-1];
    euq_pkg::trig_t [NA-1:0] trig_reg;

    // elastic stage control: a stage loads when empty or when its successor moves
    for (genvar j = 0; j <= LAST; j++) begin : g_ctl
        if (j == LAST) begin : g_end
            assign en[j] = !v_reg[j] || out_ready;
        end else begin : g_mid
            assign en[j] = !v_reg[j] || en[j+1];
        end
        if (j == 0) begin : g_first
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[j] <= 1'b0;
                end else if (en[j]) begin
                    v_reg[j] <= in_valid;
                end
            end
        end else begin : g_rest
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[j] <= 1'b0;
                end else if (en[j]) begin
                    v_reg[j] <= v_reg[j-1];
                end
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[LAST];
    assign trig      = trig_reg;

    // fold stage
    for (genvar l = 0; l < NA; l++) begin : g_fold
        logic signed [euq_pkg::ANG_W-1:0] a_in;
        logic signed [euq_pkg::ANG_W-1:0] a_clamp;
        logic signed [H_W-1:0]            h_half;
        logic signed [H_W-1:0]            h_fold;
        logic                             neg_fold;

        always_comb begin
            a_in = $signed(angle[l]);
            if (a_in > euq_pkg::ANG_LIMIT) begin
                a_clamp = euq_pkg::ANG_LIMIT;
            end else if (a_in < -euq_pkg::ANG_LIMIT) begin
                a_clamp = -euq_pkg::ANG_LIMIT;
            end else begin
                a_clamp = a_in;
            end
            h_half = H_W'(a_clamp) <<< HSH;
            if (h_half > euq_pkg::HALF_PI_Q30) begin
                h_fold   = h_half - euq_pkg::PI_Q30;
                neg_fold = 1'b1;
            end else if (h_half < -euq_pkg::HALF_PI_Q30) begin
                h_fold   = h_half + euq_pkg::PI_Q30;
                neg_fold = 1'b1;
            end else begin
                h_fold   = h_half;
                neg_fold = 1'b0;
            end
        end

        always_ff @(posedge aclk) begin
            if (en[0]) begin
                h_reg[0][l]   <= h_fold;
                neg_reg[0][l] <= neg_fold;
            end
        end
    end

    // one rotation per stage
    for (genvar k = 0; k < STEPS; k++) begin : g_iter
        localparam logic signed [H_W-1:0] ATAN_K = euq_pkg::atan_q30(k);
        for (genvar l = 0; l < NA; l++) begin : g_lane
            logic signed [XY_W-1:0] x_cur;
            logic signed [XY_W-1:0] y_cur;
            logic signed [XY_W-1:0] x_sh;
            logic signed [XY_W-1:0] y_sh;
            logic signed [XY_W-1:0] x_next;
            logic signed [XY_W-1:0] y_next;
            logic signed [H_W-1:0]  h_next;
            logic                   dir;

            if (k == 0) begin : g_init
                assign x_cur = euq_pkg::GAIN_Q30;
                assign y_cur = '0;
            end else begin : g_prev
                assign x_cur = x_reg[k][l];
                assign y_cur = y_reg[k][l];
            end

            always_comb begin
                dir  = !h_reg[k][l][H_W-1];
                x_sh = x_cur >>> k;
                y_sh = y_cur >>> k;
                if (dir) begin
                    x_next = x_cur - y_sh;
                    y_next = y_cur + x_sh;
                    h_next = h_reg[k][l] - ATAN_K;
                end else begin
                    x_next = x_cur + y_sh;
                    y_next = y_cur - x_sh;
                    h_next = h_reg[k][l] + ATAN_K;
                end
            end

            always_ff @(posedge aclk) begin
                if (en[k+1]) begin
                    x_reg[k+1][l]   <= x_next;
                    y_reg[k+1][l]   <= y_next;
                    h_reg[k+1][l]   <= h_next;
                    neg_reg[k+1][l] <= neg_reg[k][l];
                end
            end
        end
    end

    // undo the fold by negating both outputs
    for (genvar l = 0; l < NA; l++) begin : g_out
        logic signed [XY_W-1:0] x_fin;
        logic signed [XY_W-1:0] y_fin;

        always_comb begin
            x_fin = neg_reg[STEPS][l] ? -x_reg[STEPS][l] : x_reg[STEPS][l];
            y_fin = neg_reg[STEPS][l] ? -y_reg[STEPS][l] : y_reg[STEPS][l];
        end

        always_ff @(posedge aclk) begin
            if (en[LAST]) begin
                trig_reg[l].cos_v <= x_fin[euq_pkg::TRIG_W-1:0];
                trig_reg[l].sin_v <= y_fin[euq_pkg::TRIG_W-1:0];
            end
        end
    end

`ifndef SYNTHESIS
    localparam logic signed [XY_W-1:0] TRIG_BOUND = (XY_W'(1) <<< euq_pkg::Q_FRAC) + XY_W'(256);

    for (genvar l = 0; l < NA; l++) begin : g_chk
        a_fold_range: assert property (@(posedge aclk) disable iff (!aresetn)
            v_reg[0] |-> (h_reg[0][l] <= euq_pkg::HALF_PI_Q30) &&
                         (h_reg[0][l] >= -euq_pkg::HALF_PI_Q30))
            else $error("folded half angle outside +-pi/2");

        a_mag_bound: assert property (@(posedge aclk) disable iff (!aresetn)
            v_reg[STEPS] |-> (x_reg[STEPS][l] <= TRIG_BOUND) &&
                             (x_reg[STEPS][l] >= -TRIG_BOUND) &&
                             (y_reg[STEPS][l] <= TRIG_BOUND) &&
                             (y_reg[STEPS][l] >= -TRIG_BOUND))
            else $error("rotation result exceeds unit magnitude");
    end
`endif

endmodule

// ----- design/euq_mult.sv -----
// Triple-product stages: pair products, products with yaw terms, then sum, round and saturate.
module euq_mult #(
    parameter int OUT_FRAC_BITS = euq_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  euq_pkg::trig_t [euq_pkg::NUM_ANG-1:0] trig,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [euq_pkg::OUT_W-1:0]             quat_w,
    output logic [euq_pkg::OUT_W-1:0]             quat_x,
    output logic [euq_pkg::OUT_W-1:0]             quat_y,
    output logic [euq_pkg::OUT_W-1:0]             quat_z
);

    localparam int TW    = euq_pkg::TRIG_W;
    localparam int OW    = euq_pkg::OUT_W;
    localparam int SUM_W = TW + 2;
    localparam int SH    = euq_pkg::Q_FRAC - OUT_FRAC_BITS;
    localparam logic signed [SUM_W-1:0] RND = SUM_W'((64'd1 << SH) >> 1);
    localparam logic signed [SUM_W-1:0] LIM = SUM_W'(64'd1 << OUT_FRAC_BITS);

    function automatic logic signed [TW-1:0] mul_q30(input logic signed [TW-1:0] a,
                                                     input logic signed [TW-1:0] b);
        logic signed [2*TW-1:0] p;
        p = a * b;
        return p[euq_pkg::Q_FRAC+TW-1:euq_pkg::Q_FRAC];
    endfunction

    function automatic logic [OW-1:0] to_out(input logic signed [TW-1:0] a,
                                             input logic signed [TW-1:0] b,
                                             input logic                 sub);
        logic signed [SUM_W-1:0] s;
        logic signed [SUM_W-1:0] q;
        s = sub ? (SUM_W'(a) - SUM_W'(b) + RND) : (SUM_W'(a) + SUM_W'(b) + RND);
        q = s >>> SH;
        if (q > LIM) begin
            q = LIM;
        end else if (q < -LIM) begin
            q = -LIM;
        end
        return q[OW-1:0];
    endfunction

    logic [2:0] v_reg;
    logic [2:0] en;

    assign en[2]     = !v_reg[2] || out_ready;
    assign en[1]     = !v_reg[1] || en[2];
    assign en[0]     = !v_reg[0] || en[1];
    assign in_ready  = en[0];
    assign out_valid = v_reg[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) v_reg[0] <= in_valid;
            if (en[1]) v_reg[1] <= v_reg[0];
            if (en[2]) v_reg[2] <= v_reg[1];
        end
    end

    // stage A: roll times pitch
    logic signed [TW-1:0] crcp_reg, srsp_reg, crsp_reg, srcp_reg, cy_reg, sy_reg;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            crcp_reg <= mul_q30(trig[euq_pkg::LANE_ROLL].cos_v, trig[euq_pkg::LANE_PITCH].cos_v);
            srsp_reg <= mul_q30(trig[euq_pkg::LANE_ROLL].sin_v, trig[euq_pkg::LANE_PITCH].sin_v);
            crsp_reg <= mul_q30(trig[euq_pkg::LANE_ROLL].cos_v, trig[euq_pkg::LANE_PITCH].sin_v);
            srcp_reg <= mul_q30(trig[euq_pkg::LANE_ROLL].sin_v, trig[euq_pkg::LANE_PITCH].cos_v);
            cy_reg   <= trig[euq_pkg::LANE_YAW].cos_v;
            sy_reg   <= trig[euq_pkg::LANE_YAW].sin_v;
        end
    end

    // stage B: times yaw
    logic signed [TW-1:0] crcp_cy_reg, srsp_sy_reg, srcp_cy_reg, crsp_sy_reg;
    logic signed [TW-1:0] crsp_cy_reg, srcp_sy_reg, crcp_sy_reg, srsp_cy_reg;

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            crcp_cy_reg <= mul_q30(crcp_reg, cy_reg);
            srsp_sy_reg <= mul_q30(srsp_reg, sy_reg);
            srcp_cy_reg <= mul_q30(srcp_reg, cy_reg);
            crsp_sy_reg <= mul_q30(crsp_reg, sy_reg);
            crsp_cy_reg <= mul_q30(crsp_reg, cy_reg);
            srcp_sy_reg <= mul_q30(srcp_reg, sy_reg);
            crcp_sy_reg <= mul_q30(crcp_reg, sy_reg);
            srsp_cy_reg <= mul_q30(srsp_reg, cy_reg);
        end
    end

    // stage C: output register
    logic [OW-1:0] quat_w_reg, quat_x_reg, quat_y_reg, quat_z_reg;

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            quat_w_reg <= to_out(crcp_cy_reg, srsp_sy_reg, 1'b0);
            quat_x_reg <= to_out(srcp_cy_reg, crsp_sy_reg, 1'b1);
            quat_y_reg <= to_out(crsp_cy_reg, srcp_sy_reg, 1'b0);
            quat_z_reg <= to_out(crcp_sy_reg, srsp_cy_reg, 1'b1);
        end
    end

    assign quat_w = quat_w_reg;
    assign quat_x = quat_x_reg;
    assign quat_y = quat_y_reg;
    assign quat_z = quat_z_reg;

`ifndef SYNTHESIS
    localparam logic signed [OW-1:0] LIM_O = LIM[OW-1:0];
    localparam bit NARROW = (OUT_FRAC_BITS <= OW - 2);

    a_sat_wx: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && NARROW) |->
            ($signed(quat_w) <= LIM_O) && ($signed(quat_w) >= -LIM_O) &&
            ($signed(quat_x) <= LIM_O) && ($signed(quat_x) >= -LIM_O))
        else $error("w or x outside saturation bounds");

    a_sat_yz: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && NARROW) |->
            ($signed(quat_y) <= LIM_O) && ($signed(quat_y) >= -LIM_O) &&
            ($signed(quat_z) <= LIM_O) && ($signed(quat_z) >= -LIM_O))
        else $error("y or z outside saturation bounds");
`endif

endmodule

// ----- design/euler_to_quaternion.sv -----
// Top level: Euler angles (Q3.12 radians) in, quaternion (Q1.14) out.
//
// Takes yaw, pitch and roll angles in signed Q3.12 radians, clamps each to
// +-2 pi, halves it and computes its sine and cosine with a CORDIC after
// folding into +-pi/2, then forms w, x, y, z from the triple products,
// rounded to OUT_FRAC_BITS and saturated to +-1. One request in, one result
// out, no state between requests. The pipeline accepts a request every cycle
// while the output is not stalled; it has one fold stage, one stage per CORDIC
// iteration, a fold-undo stage and three multiply/sum stages. Every stage is
// elastic, so bubbles close up while the output is stalled and s_ready stays
// high until all stages hold data.
module euler_to_quaternion #(
    parameter int CORDIC_STEPS  = euq_pkg::CORDIC_STEPS_DEF,
    parameter int OUT_FRAC_BITS = euq_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [euq_pkg::ANG_W-1:0] s_angle_x,
    input  logic signed [euq_pkg::ANG_W-1:0] s_angle_y,
    input  logic signed [euq_pkg::ANG_W-1:0] s_angle_z,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [euq_pkg::OUT_W-1:0] m_quat_w,
    output logic signed [euq_pkg::OUT_W-1:0] m_quat_x,
    output logic signed [euq_pkg::OUT_W-1:0] m_quat_y,
    output logic signed [euq_pkg::OUT_W-1:0] m_quat_z
);

    logic [euq_pkg::NUM_ANG-1:0][euq_pkg::ANG_W-1:0] angle;
    euq_pkg::trig_t [euq_pkg::NUM_ANG-1:0]           trig;
    logic                                            trig_valid;
    logic                                            trig_ready;

    assign angle[euq_pkg::LANE_YAW]   = s_angle_x;
    assign angle[euq_pkg::LANE_PITCH] = s_angle_y;
    assign angle[euq_pkg::LANE_ROLL]  = s_angle_z;

    euq_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .angle     (angle),
        .out_valid (trig_valid),
        .out_ready (trig_ready),
        .trig      (trig)
    );

    euq_mult #(
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_mult (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (trig_valid),
        .in_ready  (trig_ready),
        .trig      (trig),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .quat_w    (m_quat_w),
        .quat_x    (m_quat_x),
        .quat_y    (m_quat_y),
        .quat_z    (m_quat_z)
    );

`ifndef SYNTHESIS
    // a free output slot ripples back through every stage
    a_ready_path: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_ready || !m_valid) |-> s_ready)
        else $error("input stalled although output side can move");

    a_trig_link: assert property (@(posedge aclk) disable iff (!aresetn)
        (trig_valid && !trig_ready) |-> m_valid)
        else $error("CORDIC stalled while multiplier output is empty");
`endif

endmodule
